/* hdl/lane_position_history_average_defines.svh */
// assertion macros for the lane position history averager
`ifndef LANE_POSITION_HISTORY_AVERAGE_DEFINES_SVH
`define LANE_POSITION_HISTORY_AVERAGE_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define LPHA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpha same-cycle check failed");

// antecedent holds, consequent holds in the next cycle
`define LPHA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpha next-cycle check failed");

`endif

/* hdl/lpha_pkg.sv */
// shared types for the lane position history averager
package lpha_pkg;

	// status of the serial divider as seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* hdl/lpha_ram.sv */
// generic single-write, single-read ram with registered read data
module lpha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/lpha_div.sv */
// serial signed divider, one quotient bit per cycle, truncating toward zero
module lpha_div #(
	parameter int SUM_W = 20,
	parameter int DIV_W = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SUM_W-1:0]  dividend,
	input  logic [DIV_W-1:0]         divisor,
	output logic signed [SUM_W-1:0]  quotient,
	output lpha_pkg::div_stat_t      stat
);

	localparam int CNT_W = $clog2(SUM_W + 1);

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_FIX
	} dv_state_t;

	dv_state_t          state_q;
	logic [SUM_W-1:0]   mag_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic [SUM_W-1:0]   quo_q;
	logic               done_q;

	logic [DIV_W:0]     rem_sh;
	logic               ge;
	logic [DIV_W:0]     rem_sub;

	// one restoring step
	assign rem_sh  = {rem_q, mag_q[SUM_W-1]};
	assign ge      = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			mag_q   <= '0;
			rem_q   <= '0;
			dvs_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			quo_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					if (start) begin
						neg_q   <= dividend[SUM_W-1];
						mag_q   <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
						dvs_q   <= divisor;
						rem_q   <= '0;
						cnt_q   <= CNT_W'(SUM_W);
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					rem_q <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
					mag_q <= {mag_q[SUM_W-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= DV_FIX;
					end
				end
				DV_FIX: begin
					quo_q   <= neg_q ? (~mag_q + 1'b1) : mag_q;
					done_q  <= 1'b1;
					state_q <= DV_IDLE;
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	assign quotient  = signed'(quo_q);
	assign stat.busy = (state_q != DV_IDLE);
	assign stat.done = done_q;

endmodule

/* hdl/lane_position_history_average.sv */
// top level: lane position history averager with a shared serial divider
//
// Takes one frame's lane coordinates (left and right, top and bottom x, all-ones
// meaning not detected) and returns one transfer per input with the mean of each
// side's last HISTORY_DEPTH stored pairs, skipping entries whose top x is zero.
// A side is stored only when at least one of its two coordinates is detected.
// Means truncate toward zero; a side with nothing counted gives zero. Both
// histories read as all zero after reset (per-entry valid bits, no clearing pass).
// Timing: one item at a time. After the input transfer the sequencer writes the
// histories, walks both history rams in step and accumulates, then runs four
// divisions through the one serial divider at one quotient bit a cycle; the
// divider dominates the time per item. The result sits in an output register,
// so the next input is taken while it waits.
module lane_position_history_average #(
	parameter int HISTORY_DEPTH = 8,
	parameter int COORD_WIDTH   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// left_top_x, left_bottom_x, right_top_x, right_bottom_x, zero padding
	input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// left_top_mean, left_bottom_mean, right_top_mean, right_bottom_mean, zero padding
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

`include "lane_position_history_average_defines.svh"

	localparam int W      = COORD_WIDTH;
	localparam int DATA_W = ((4*W+7)/8)*8;
	localparam int PAD_W  = DATA_W - 4*W;
	localparam int ADDR_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = W + CNT_W;
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(HISTORY_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;

	// captured input pairs and push decisions
	logic [W-1:0] lt_q, lb_q, rt_q, rb_q;
	logic         push_l_q, push_r_q;

	// history bookkeeping: write pointers and per-entry valid bits
	logic [ADDR_W-1:0]        wptr_l_q, wptr_r_q;
	logic [HISTORY_DEPTH-1:0] vld_l_q, vld_r_q;

	// scan pipeline
	logic [ADDR_W-1:0] rd_addr_q;
	logic              rd_en_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [2*W-1:0]    rdata_l, rdata_r;

	// accumulators: sums ordered left top, left bottom, right top, right bottom
	logic signed [SUM_W-1:0] sum_q [4];
	logic [CNT_W-1:0]        cnt_l_q, cnt_r_q;

	// division sequencing and results
	logic [1:0]              sel_q;
	logic [W-1:0]            mean_q [4];
	logic                    m_valid_q;
	logic [4*W-1:0]          m_data_q;

	logic                    div_start;
	logic signed [SUM_W-1:0] div_quo;
	lpha_pkg::div_stat_t     div_stat;
	logic [CNT_W-1:0]        div_cnt;

	logic                    in_xfer;
	logic                    use_l, use_r;
	logic [W-1:0]            l_top, l_bot, r_top, r_bot;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// both history rams share the read address, so the two sides are walked in step
	lpha_ram #(
		.WIDTH(2*W),
		.DEPTH(HISTORY_DEPTH)
	) u_ram_l (
		.clk  (clk),
		.we   ((state_q == ST_PUSH) && push_l_q),
		.waddr(wptr_l_q),
		.wdata({lb_q, lt_q}),
		.raddr(rd_addr_q),
		.rdata(rdata_l)
	);

	lpha_ram #(
		.WIDTH(2*W),
		.DEPTH(HISTORY_DEPTH)
	) u_ram_r (
		.clk  (clk),
		.we   ((state_q == ST_PUSH) && push_r_q),
		.waddr(wptr_r_q),
		.wdata({rb_q, rt_q}),
		.raddr(rd_addr_q),
		.rdata(rdata_r)
	);

	// an entry counts only when it has been written and its top x is not zero
	assign l_top = rdata_l[W-1:0];
	assign l_bot = rdata_l[2*W-1:W];
	assign r_top = rdata_r[W-1:0];
	assign r_bot = rdata_r[2*W-1:W];
	assign use_l = rd_en_s1 && vld_l_q[idx_s1] && (l_top != '0);
	assign use_r = rd_en_s1 && vld_r_q[idx_s1] && (r_top != '0);

	// the single shared divider, fed one sum at a time
	assign div_start = (state_q == ST_DIV_GO);
	assign div_cnt   = sel_q[1] ? cnt_r_q : cnt_l_q;

	lpha_div #(
		.SUM_W(SUM_W),
		.DIV_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q[sel_q]),
		.divisor (div_cnt),
		.quotient(div_quo),
		.stat    (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lt_q      <= '0;
			lb_q      <= '0;
			rt_q      <= '0;
			rb_q      <= '0;
			push_l_q  <= 1'b0;
			push_r_q  <= 1'b0;
			wptr_l_q  <= '0;
			wptr_r_q  <= '0;
			vld_l_q   <= '0;
			vld_r_q   <= '0;
			rd_addr_q <= '0;
			rd_en_s1  <= 1'b0;
			idx_s1    <= '0;
			for (int i = 0; i < 4; i++) begin
				sum_q[i]  <= '0;
				mean_q[i] <= '0;
			end
			cnt_l_q   <= '0;
			cnt_r_q   <= '0;
			sel_q     <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			// scan pipeline stage one holds the read address registered, in step with the ram read data
			rd_en_s1 <= (state_q == ST_SCAN);
			idx_s1   <= rd_addr_q;

			if (use_l) begin
				sum_q[0] <= sum_q[0] + SUM_W'(signed'(l_top));
				sum_q[1] <= sum_q[1] + SUM_W'(signed'(l_bot));
				cnt_l_q  <= cnt_l_q + 1'b1;
			end
			if (use_r) begin
				sum_q[2] <= sum_q[2] + SUM_W'(signed'(r_top));
				sum_q[3] <= sum_q[3] + SUM_W'(signed'(r_bot));
				cnt_r_q  <= cnt_r_q + 1'b1;
			end

			// result handed over downstream; a refill in the finish state takes over
			if (m_valid_q && m_axis_tready && (state_q != ST_FINISH)) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						lt_q     <= s_axis_tdata[W-1:0];
						lb_q     <= s_axis_tdata[2*W-1:W];
						rt_q     <= s_axis_tdata[3*W-1:2*W];
						rb_q     <= s_axis_tdata[4*W-1:3*W];
						// a side with both coordinates all ones is not stored
						push_l_q <= !((s_axis_tdata[W-1:0] == '1) &&
							(s_axis_tdata[2*W-1:W] == '1));
						push_r_q <= !((s_axis_tdata[3*W-1:2*W] == '1) &&
							(s_axis_tdata[4*W-1:3*W] == '1));
						state_q  <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					// ram write happens this cycle; oldest entry is overwritten
					if (push_l_q) begin
						vld_l_q[wptr_l_q] <= 1'b1;
						wptr_l_q <= (wptr_l_q == LAST) ? '0 : wptr_l_q + 1'b1;
					end
					if (push_r_q) begin
						vld_r_q[wptr_r_q] <= 1'b1;
						wptr_r_q <= (wptr_r_q == LAST) ? '0 : wptr_r_q + 1'b1;
					end
					for (int i = 0; i < 4; i++) begin
						sum_q[i] <= '0;
					end
					cnt_l_q   <= '0;
					cnt_r_q   <= '0;
					rd_addr_q <= '0;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_addr_q == LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// last entry is accumulated on this edge
					sel_q   <= '0;
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_stat.done) begin
						mean_q[sel_q] <= (div_cnt == '0) ? '0 : div_quo[W-1:0];
						if (sel_q == 2'd3) begin
							state_q <= ST_FINISH;
						end else begin
							sel_q   <= sel_q + 1'b1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_FINISH: begin
					// wait for the output register to be free
					if (!m_valid_q || m_axis_tready) begin
						m_data_q  <= {mean_q[3], mean_q[2], mean_q[1], mean_q[0]};
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;

	if (PAD_W > 0) begin : g_pad
		assign m_axis_tdata = {{PAD_W{1'b0}}, m_data_q};
	end else begin : g_nopad
		assign m_axis_tdata = m_data_q;
	end

	// divider only runs while the sequencer waits on it
	`LPHA_ASSERT_SAME(a_div_idle_when_ready, s_axis_tready, !div_stat.busy)
	// divider completion is only seen while the sequencer waits for it
	`LPHA_ASSERT_SAME(a_done_in_wait, div_stat.done, state_q == ST_DIV_WAIT)
	// an accepted item always goes to the history write first
	`LPHA_ASSERT_NEXT(a_accept_to_push, in_xfer, state_q == ST_PUSH)
	// counts never exceed the history depth
	`LPHA_ASSERT_SAME(a_count_bound, 1'b1,
		(cnt_l_q <= CNT_W'(HISTORY_DEPTH)) && (cnt_r_q <= CNT_W'(HISTORY_DEPTH)))

endmodule

/* tb/lane_position_history_average_tb.sv */
// self-checking testbench for the lane position history averager
module lane_position_history_average_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HIST_DEPTH  = 8;
	localparam int COORD_W     = 16;
	localparam int DATA_W      = ((4*COORD_W+7)/8)*8;
	localparam int CLK_PERIOD  = 20;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_FRAMES = 550;
	localparam int MAX_IDLE    = 16;
	// extra wait at the end, covering a frame's time in the block plus idling on both sides
	localparam int DRAIN_CYCLES = 150;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 600;

	// coordinate codes
	localparam int NOT_FOUND = -1;
	localparam int COORD_MIN = -32768;
	localparam int COORD_MAX = 32767;

	// points in the random part where the pressure scenarios kick in
	localparam int CALM_FIRST  = 150;
	localparam int CALM_LAST   = 199;
	localparam int HOLD_FIRST  = 300;
	localparam int HOLD_LAST   = 340;
	localparam int DRAIN_POINT = 420;

	// one side of a frame, top x in the low half as on the bus
	typedef struct packed {
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] top;
	} lane_pair_t;

	// directed frame with an optional hand-worked result
	typedef struct {
		int  lt, lb, rt, rb;
		bit  worked;
		int  elt, elb, ert, erb;
	} frame_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [DATA_W-1:0] m_axis_tdata;

	// our own copy of both histories, index 0 left and 1 right, newest first
	lane_pair_t lane_hist [2][HIST_DEPTH];
	// means still owed by the block, oldest first
	logic [DATA_W-1:0] expected_means [$];
	int fail_count = 0;
	int cycle_count = 0;
	// flags from the sender to the receiver
	bit calm_window = 1'b0;
	bit hold_pending = 1'b0;

	string MEAN_NAMES [4] = '{"left_top_mean", "left_bottom_mean",
		"right_top_mean", "right_bottom_mean"};

	// directed frames: empty history, zero tops, lone -1 values,
	// truncation of odd sums, and histories filled with the extremes
	frame_row_t directed_rows [25] = '{
		'{NOT_FOUND, NOT_FOUND, NOT_FOUND, NOT_FOUND, 1'b1, 0, 0, 0, 0},
		'{0, 500, NOT_FOUND, NOT_FOUND, 1'b1, 0, 0, 0, 0},
		'{100, 200, NOT_FOUND, NOT_FOUND, 1'b1, 100, 200, 0, 0},
		'{NOT_FOUND, NOT_FOUND, COORD_MAX, COORD_MIN, 1'b1, 100, 200, COORD_MAX, COORD_MIN},
		'{NOT_FOUND, 300, NOT_FOUND, NOT_FOUND, 1'b0, 0, 0, 0, 0},
		'{NOT_FOUND, NOT_FOUND, COORD_MIN, COORD_MAX, 1'b0, 0, 0, 0, 0},
		'{7, NOT_FOUND, -3, -5, 1'b0, 0, 0, 0, 0},
		'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, 0, 0, 0, 0},
		'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, 0, 0, 0, 0},
		'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, 0, 0, 0, 0},
		'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, 0, 0, 0, 0},
		'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, 0, 0, 0, 0},
		'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, 0, 0, 0, 0},
		'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, 0, 0, 0, 0},
		'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1,
			COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX},
		'{COORD_MAX, COORD_MIN, 1, 0, 1'b0, 0, 0, 0, 0},
		'{COORD_MAX, COORD_MIN, 1, 0, 1'b0, 0, 0, 0, 0},
		'{COORD_MAX, COORD_MIN, 1, 0, 1'b0, 0, 0, 0, 0},
		'{COORD_MAX, COORD_MIN, 1, 0, 1'b0, 0, 0, 0, 0},
		'{COORD_MAX, COORD_MIN, 1, 0, 1'b0, 0, 0, 0, 0},
		'{COORD_MAX, COORD_MIN, 1, 0, 1'b0, 0, 0, 0, 0},
		'{COORD_MAX, COORD_MIN, 1, 0, 1'b0, 0, 0, 0, 0},
		'{COORD_MAX, COORD_MIN, 1, 0, 1'b1, COORD_MAX, COORD_MIN, 1, 0},
		'{0, COORD_MAX, NOT_FOUND, NOT_FOUND, 1'b1, COORD_MAX, COORD_MIN, 1, 0},
		'{NOT_FOUND, NOT_FOUND, 0, 0, 1'b1, COORD_MAX, COORD_MIN, 1, 0}
	};

	lane_position_history_average #(
		.HISTORY_DEPTH(HIST_DEPTH),
		.COORD_WIDTH  (COORD_W)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// pushes a frame's found sides into the histories and returns the four means
	function automatic logic [DATA_W-1:0] predict_lane_means(logic [DATA_W-1:0] frame);
		lane_pair_t in_pair;
		int sum_top;
		int sum_bottom;
		int counted;
		logic [DATA_W-1:0] means;
		means = '0;
		for (int s = 0; s < 2; s++) begin
			in_pair = frame[s*2*COORD_W +: 2*COORD_W];
			// a side with neither coordinate found leaves its history alone
			if (!(in_pair.top == COORD_W'(NOT_FOUND) && in_pair.bottom == COORD_W'(NOT_FOUND))) begin
				for (int i = HIST_DEPTH-1; i > 0; i--)
					lane_hist[s][i] = lane_hist[s][i-1];
				lane_hist[s][0] = in_pair;
			end
			sum_top = 0;
			sum_bottom = 0;
			counted = 0;
			for (int i = 0; i < HIST_DEPTH; i++) begin
				// a zero top marks an entry that does not count
				if (lane_hist[s][i].top != '0) begin
					sum_top += lane_hist[s][i].top;
					sum_bottom += lane_hist[s][i].bottom;
					counted++;
				end
			end
			// integer division truncates toward zero
			if (counted != 0) begin
				means[s*2*COORD_W +: COORD_W] = COORD_W'(sum_top / counted);
				means[s*2*COORD_W+COORD_W +: COORD_W] = COORD_W'(sum_bottom / counted);
			end
		end
		return means;
	endfunction

	function automatic logic [COORD_W-1:0] pick_extreme_coord();
		case ($urandom_range(0, 5))
			0: return COORD_W'(COORD_MIN);
			1: return COORD_W'(COORD_MAX);
			2: return COORD_W'(NOT_FOUND);
			3: return '0;
			4: return COORD_W'(1);
			default: return COORD_W'(-2);
		endcase
	endfunction

	// one side of a random frame: mostly plausible lane positions
	function automatic lane_pair_t pick_side_pair();
		lane_pair_t p;
		int mode;
		mode = $urandom_range(0, 99);
		p.top = COORD_W'(int'($urandom_range(0, 2300)) - 200);
		p.bottom = COORD_W'(int'($urandom_range(0, 2300)) - 200);
		if (mode < 50) begin
			// plausible positions as drawn above
		end else if (mode < 62) begin
			p.top = COORD_W'(NOT_FOUND);
			p.bottom = COORD_W'(NOT_FOUND);
		end else if (mode < 68) begin
			p.top = COORD_W'(NOT_FOUND);
		end else if (mode < 74) begin
			p.bottom = COORD_W'(NOT_FOUND);
		end else if (mode < 80) begin
			p.top = '0;
		end else if (mode < 92) begin
			p = $urandom;
		end else begin
			p.top = pick_extreme_coord();
			p.bottom = pick_extreme_coord();
		end
		return p;
	endfunction

	// offers one frame after a gap; called and returns at a falling edge
	task automatic send_frame(input logic [DATA_W-1:0] frame, input int gap,
		input bit worked, input logic [DATA_W-1:0] worked_means);
		logic [DATA_W-1:0] predicted;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= frame;
		do @(posedge clk); while (!s_axis_tready);
		predicted = predict_lane_means(frame);
		expected_means.push_back(worked ? worked_means : predicted);
		@(negedge clk);
	endtask

	// holds the sender until the block has handed back everything
	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (expected_means.size() != 0);
	endtask

	// stimulus
	initial begin
		logic [DATA_W-1:0] frame;
		logic [DATA_W-1:0] worked_means;
		int gap;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		for (int s = 0; s < 2; s++)
			for (int i = 0; i < HIST_DEPTH; i++)
				lane_hist[s][i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r]) begin
			frame = {COORD_W'(directed_rows[r].rb), COORD_W'(directed_rows[r].rt),
				COORD_W'(directed_rows[r].lb), COORD_W'(directed_rows[r].lt)};
			worked_means = {COORD_W'(directed_rows[r].erb), COORD_W'(directed_rows[r].ert),
				COORD_W'(directed_rows[r].elb), COORD_W'(directed_rows[r].elt)};
			send_frame(frame, $urandom_range(0, MAX_IDLE), directed_rows[r].worked,
				worked_means);
		end
		// sender pause until the block is empty
		wait_for_drain();

		for (int n = 0; n < RANDOM_FRAMES; n++) begin
			calm_window = (n >= CALM_FIRST && n <= CALM_LAST);
			// the receiver holds off for a long stretch while frames keep coming
			if (n == HOLD_FIRST)
				hold_pending = 1'b1;
			if (n == DRAIN_POINT)
				wait_for_drain();
			if (calm_window || (n >= HOLD_FIRST && n <= HOLD_LAST))
				gap = 0;
			else if ($urandom_range(0, 3) == 0)
				gap = 0;
			else
				gap = $urandom_range(0, MAX_IDLE);
			frame = {pick_side_pair(), pick_side_pair()};
			send_frame(frame, gap, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		calm_window = 1'b0;

		while (expected_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_means.size() == 0)
			$display("** lane_position_history_average: PASSED **");
		else
			$display("** lane_position_history_average: FAILED **");
		$finish;
	end

	// result side back-pressure
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_pending) begin
				stall = LONG_HOLD;
				hold_pending = 1'b0;
			end else if (calm_window || $urandom_range(0, 3) == 0)
				stall = 0;
			else
				stall = $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// compare every result transfer with the oldest owed means
	always @(posedge clk) begin : check_means
		logic [DATA_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_means.size() == 0) begin
				$error("result transfer with no frame outstanding: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_means.pop_front();
				for (int f = 0; f < 4; f++) begin
					if (m_axis_tdata[f*COORD_W +: COORD_W] !== want[f*COORD_W +: COORD_W]) begin
						$error("%s mismatch: expected %0d, got %0d", MEAN_NAMES[f],
							$signed(want[f*COORD_W +: COORD_W]),
							$signed(m_axis_tdata[f*COORD_W +: COORD_W]));
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** lane_position_history_average: FAILED **");
			$finish;
		end
	end

endmodule
